FILE: hdl/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the CAN transmit buffer scheduler
// Word layouts, event kinds, status and report codes, state and register sets.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int MAX_BUFFERS = 32;
    localparam int NUM_BUF     = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;

    // event kinds
    localparam logic [2:0] KIND_SEND     = 3'd0;
    localparam logic [2:0] KIND_TX_DONE  = 3'd1;
    localparam logic [2:0] KIND_CLR_SYNC = 3'd2;
    localparam logic [2:0] KIND_BUS_OFF  = 3'd3;
    localparam logic [2:0] KIND_OVERRUN  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_WINDOW   = 2'd2;
    localparam logic [1:0] ST_BAD_IDX  = 2'd3;

    // report codes
    localparam logic [2:0] RPT_NONE       = 3'd0;
    localparam logic [2:0] RPT_OVERFLOW   = 3'd1;
    localparam logic [2:0] RPT_WIN_SEND   = 3'd2;
    localparam logic [2:0] RPT_WIN_PURGE  = 3'd3;
    localparam logic [2:0] RPT_WIN_DEFER  = 3'd4;

    // sticky error bits
    localparam logic [1:0] ERR_BUS_OFF = 2'b01;
    localparam logic [1:0] ERR_OVERRUN = 2'b10;

    // configuration register indexes
    localparam logic [1:0] CFG_BUFFERS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_SYNC_MASK      = 2'd1;
    localparam logic [1:0] CFG_WINDOW_CHECK   = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] buffer_index;
        logic             hw_queue_full;
        logic             in_window;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic             send_now;
        logic [IDX_W-1:0] sent_index;
        logic [2:0]       report_code;
        logic             purge_tx;
        logic [1:0]       error_flags;
    } t_out_word;

    typedef struct packed {
        logic [NUM_BUF-1:0] full_bits;
        logic [CNT_W-1:0]   pending_count;
        logic               first_unsent;
        logic               inhibit_flag;
        logic [1:0]         sticky_errors;
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]   buffers_in_use;
        logic [NUM_BUF-1:0] sync_mask;
        logic               window_check_enable;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_pick;

endpackage
`default_nettype wire

FILE: hdl/cts_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_in_if: request/event word channel
// Valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface cts_in_if;
    import cts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/cts_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_out_if: result word channel
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface cts_out_if;
    import cts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/cts_pick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pick: lowest full buffer search
// Masks the full bits to the active buffers and encodes the lowest set bit.
// ----------------------------------------------------------------------------
module cts_pick
    import cts_pkg::*;
(
    input  wire logic [NUM_BUF-1:0] i_full_bits,
    input  wire logic [CNT_W-1:0]   i_limit,
    output t_pick                   o_pick
);

    logic [NUM_BUF-1:0] active_mask;
    logic [NUM_BUF-1:0] cand;
    logic [NUM_BUF-1:0] lowest;
    logic [IDX_W-1:0]   enc;

    // build the mask of buffers below the limit
    always_comb begin
        if (i_limit >= CNT_W'(NUM_BUF)) begin
            active_mask = {NUM_BUF{1'b1}};
        end else begin
            active_mask = (NUM_BUF'(1) << i_limit[IDX_W-1:0]) - NUM_BUF'(1);
        end
    end

    // isolate the lowest set bit
    assign cand   = i_full_bits & active_mask;
    assign lowest = cand & (~cand + NUM_BUF'(1));

    // encode the one-hot position
    always_comb begin
        enc = '0;
        for (int i = 0; i < NUM_BUF; i++) begin
            if (lowest[i]) begin
                enc = enc | IDX_W'(i);
            end
        end
    end

    assign o_pick.found = |cand;
    assign o_pick.index = enc;

endmodule
`default_nettype wire

FILE: hdl/cts_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_step: per-word scheduling decision
// Computes the result word and the next scheduler state for one word.
// ----------------------------------------------------------------------------
module cts_step
    import cts_pkg::*;
(
    input  wire t_in_word  i_word,
    input  wire t_state    i_state,
    input  wire t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_word o_res
);

    logic [CNT_W-1:0]   limit;
    logic [NUM_BUF-1:0] req_bit;
    logic [NUM_BUF-1:0] pick_bit;
    t_pick              pick;

    // clamp the active buffer count
    assign limit = (i_cfg.buffers_in_use > CNT_W'(MAX_BUFFERS)) ?
                   CNT_W'(MAX_BUFFERS) : i_cfg.buffers_in_use;

    assign req_bit  = NUM_BUF'(1) << i_word.buffer_index;
    assign pick_bit = NUM_BUF'(1) << pick.index;

    cts_pick u_pick (
        .i_full_bits (i_state.full_bits),
        .i_limit     (limit),
        .o_pick      (pick)
    );

    // decide result and next state
    always_comb begin
        o_state            = i_state;
        o_res.status       = ST_OK;
        o_res.send_now     = 1'b0;
        o_res.sent_index   = '0;
        o_res.report_code  = RPT_NONE;
        o_res.purge_tx     = 1'b0;
        case (i_word.kind)
            KIND_SEND: begin
                if ({1'b0, i_word.buffer_index} >= limit) begin
                    o_res.status = ST_BAD_IDX;
                end else if ((i_state.full_bits & req_bit) != '0) begin
                    o_res.status = ST_OVERFLOW;
                    if (!i_state.first_unsent) begin
                        o_res.report_code = RPT_OVERFLOW;
                    end
                end else if (i_cfg.window_check_enable &&
                             ((i_cfg.sync_mask & req_bit) != '0) &&
                             !i_word.in_window) begin
                    o_res.status      = ST_WINDOW;
                    o_res.report_code = RPT_WIN_SEND;
                end else if (i_word.hw_queue_full) begin
                    o_state.full_bits = i_state.full_bits | req_bit;
                    if (i_state.pending_count != CNT_MAX) begin
                        o_state.pending_count = i_state.pending_count + CNT_W'(1);
                    end
                end else begin
                    o_res.send_now   = 1'b1;
                    o_res.sent_index = i_word.buffer_index;
                end
            end
            KIND_TX_DONE: begin
                o_state.first_unsent = 1'b0;
                o_state.inhibit_flag = 1'b0;
                if (i_state.pending_count != '0) begin
                    o_state.pending_count = i_state.pending_count - CNT_W'(1);
                    if (pick.found) begin
                        o_state.full_bits = i_state.full_bits & ~pick_bit;
                        if (i_cfg.window_check_enable &&
                            ((i_cfg.sync_mask & pick_bit) != '0) &&
                            !i_word.in_window) begin
                            // drop the buffer outside the window
                            o_res.report_code = RPT_WIN_DEFER;
                        end else begin
                            if (i_cfg.window_check_enable &&
                                ((i_cfg.sync_mask & pick_bit) != '0)) begin
                                o_state.inhibit_flag = 1'b1;
                            end
                            o_res.send_now   = 1'b1;
                            o_res.sent_index = pick.index;
                        end
                    end
                end
            end
            KIND_CLR_SYNC: begin
                if (i_state.inhibit_flag) begin
                    o_res.purge_tx    = 1'b1;
                    o_res.report_code = RPT_WIN_PURGE;
                end
            end
            KIND_BUS_OFF: begin
                o_state.sticky_errors = i_state.sticky_errors | ERR_BUS_OFF;
            end
            KIND_OVERRUN: begin
                o_state.sticky_errors = i_state.sticky_errors | ERR_OVERRUN;
            end
            default: begin
            end
        endcase
        o_res.error_flags = o_state.sticky_errors;
    end

endmodule
`default_nettype wire

FILE: hdl/can_tx_buffer_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input word is held in the input register, then its result word is registered in the result register.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the stage after them is free or draining.
// The lowest-full-buffer search over 32 bits sits in the single logic stage.
// Reset (synchronous, active low) clears valids and scheduler state, sets the first-unsent flag and sets the
// configuration registers to 32 buffers, no sync buffers, window check off.
// ----------------------------------------------------------------------------
// can_tx_buffer_scheduler: CAN transmit buffer scheduler
// Handles send requests and tx events against a set of pending buffers.
// ----------------------------------------------------------------------------
module can_tx_buffer_scheduler
    import cts_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    cts_in_if.sink            i_req,
    cts_out_if.source         o_res
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_word n_out;
    logic      out_free;
    logic      advance;
    logic      in_ready;

    // handshake: result register frees on take, input register on advance
    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = r_in_valid && out_free;
    assign in_ready = !r_in_valid || out_free;

    assign i_req.ready   = in_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    cts_step u_step (
        .i_word  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // hold the accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
        if (in_ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    // register the result and commit the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid           <= 1'b0;
            r_state.full_bits     <= '0;
            r_state.pending_count <= '0;
            r_state.first_unsent  <= 1'b1;
            r_state.inhibit_flag  <= 1'b0;
            r_state.sticky_errors <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffers_in_use      <= CNT_W'(32);
            r_cfg.sync_mask           <= '0;
            r_cfg.window_check_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUFFERS_IN_USE: r_cfg.buffers_in_use <= i_cfg_data[CNT_W-1:0];
                CFG_SYNC_MASK:      r_cfg.sync_mask      <= i_cfg_data[NUM_BUF-1:0];
                CFG_WINDOW_CHECK:   r_cfg.window_check_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // no send means a zero index
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.send_now |-> r_out.sent_index == '0)
        else $error("sent_index nonzero without send_now");

    // purge only with its report code
    a_purge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.purge_tx |-> r_out.report_code == RPT_WIN_PURGE)
        else $error("purge_tx without purge report");

    // the bus-off sticky error never clears outside reset
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sticky_errors[0] |=> r_state.sticky_errors[0])
        else $error("bus off flag cleared");

    // first message flag drops only on tx complete
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.first_unsent) |-> $past(advance && r_in.kind == KIND_TX_DONE))
        else $error("first_unsent cleared by other event");

endmodule
`default_nettype wire
